[rtl/core/psns_pkg.sv]
// shared types and constants for the nearest-neighbor pixel scaler
package psns_pkg;

	localparam int unsigned PIX_W          = 24;
	localparam int unsigned FACTOR_W       = 7;
	localparam int unsigned STEP_W         = 16;
	localparam int unsigned ROWW_W         = 13;
	localparam int unsigned CFG_DATA_W     = 16;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned DEF_MAX_WIDTH  = 4096;
	localparam int unsigned DEF_MAX_FACTOR = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GROW_MODE   = 2'd0,
		REG_GROW_FACTOR = 2'd1,
		REG_DROP_STEP   = 2'd2,
		REG_ROW_WIDTH   = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		REQ_PIXEL  = 1'b0,
		REQ_REPLAY = 1'b1
	} req_t;

	// one decided request on its way to the repeater
	typedef struct packed {
		logic [PIX_W-1:0]    pixel;
		logic [FACTOR_W-1:0] count;
		logic                ends_row;
		logic                err;
		logic                use_store;
	} job_t;

endpackage

[rtl/core/psns_line_store.sv]
// line store: one write port, one registered read port
module psns_line_store #(
	parameter int unsigned DEPTH = psns_pkg::DEF_MAX_WIDTH,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [psns_pkg::PIX_W-1:0]   wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [psns_pkg::PIX_W-1:0]   rdata
);
	import psns_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

[rtl/core/psns_ctrl.sv]
// config registers, scaling state and the per-request decision stage
module psns_ctrl #(
	parameter int unsigned MAX_WIDTH  = psns_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_FACTOR = psns_pkg::DEF_MAX_FACTOR,
	parameter int unsigned CW         = $clog2(MAX_WIDTH)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psns_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psns_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            in_req,
	input  logic [psns_pkg::PIX_W-1:0]      in_pixel,
	input  logic                            job_take,
	output logic                            job_valid,
	output psns_pkg::job_t                  job,
	output logic                            mem_we,
	output logic                            mem_re,
	output logic [CW-1:0]                   mem_addr,
	output logic [psns_pkg::PIX_W-1:0]      mem_wdata
);
	import psns_pkg::*;

	localparam int unsigned CW1 = CW + 1;
	localparam int unsigned RW  = $clog2(MAX_FACTOR);
	localparam int unsigned XW  = (CW1 > ROWW_W) ? CW1 : ROWW_W;

	logic                grow_mode_q;
	logic [FACTOR_W-1:0] grow_factor_q;
	logic [STEP_W-1:0]   drop_step_q;
	logic [ROWW_W-1:0]   row_width_q;

	logic [CW-1:0]       col_q, col_n, next_col;
	logic [STEP_W-1:0]   row_acc_q, row_acc_n, col_acc_q, col_acc_n, col_base;
	logic                row_drop_q, row_drop_n, drop_row;
	logic [RW-1:0]       replays_q, replays_n;

	logic                s1_valid_s1;
	job_t                job_s1;

	logic [CW1-1:0]      width_eff;
	logic [XW-1:0]       row_width_x;
	logic [FACTOR_W-1:0] factor_eff;
	logic                at_end, accept, live, do_write, do_read;
	logic [STEP_W:0]     row_sum, col_sum;
	job_t                job_d;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grow_mode_q   <= 1'b0;
			grow_factor_q <= FACTOR_W'(1);
			drop_step_q   <= '0;
			row_width_q   <= ROWW_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GROW_MODE:   grow_mode_q   <= cfg_data[0];
				REG_GROW_FACTOR: grow_factor_q <= cfg_data[FACTOR_W-1:0];
				REG_DROP_STEP:   drop_step_q   <= cfg_data[STEP_W-1:0];
				REG_ROW_WIDTH:   row_width_q   <= cfg_data[ROWW_W-1:0];
				default:         ;
			endcase
		end
	end

	// clamp width and factor to their legal ranges
	assign row_width_x = XW'(row_width_q);
	always_comb begin
		if (row_width_q == '0) begin
			width_eff = CW1'(1);
		end else if (row_width_x > XW'(MAX_WIDTH)) begin
			width_eff = CW1'(MAX_WIDTH);
		end else begin
			width_eff = CW1'(row_width_q);
		end
		if (grow_factor_q == '0) begin
			factor_eff = FACTOR_W'(1);
		end else if (grow_factor_q > FACTOR_W'(MAX_FACTOR)) begin
			factor_eff = FACTOR_W'(MAX_FACTOR);
		end else begin
			factor_eff = grow_factor_q;
		end
	end

	assign accept   = in_valid && in_ready;
	assign in_ready = !s1_valid_s1 || job_take;
	assign at_end   = ({1'b0, col_q} + CW1'(1)) >= width_eff;
	assign next_col = at_end ? '0 : col_q + CW'(1);

	// shrink accumulators, row start restarts the column accumulator
	assign row_sum  = {1'b0, row_acc_q} + {1'b0, drop_step_q};
	assign col_base = (col_q == '0) ? '0 : col_acc_q;
	assign drop_row = (col_q == '0) ? row_sum[STEP_W] : row_drop_q;
	assign col_sum  = {1'b0, col_base} + {1'b0, drop_step_q};

	always_comb begin
		col_n      = col_q;
		row_acc_n  = row_acc_q;
		col_acc_n  = col_acc_q;
		row_drop_n = row_drop_q;
		replays_n  = replays_q;
		live       = 1'b1;
		do_write   = 1'b0;
		do_read    = 1'b0;
		job_d      = '0;
		job_d.count = FACTOR_W'(1);
		if (!grow_mode_q) begin
			if (in_req == REQ_REPLAY) begin
				job_d.err = 1'b1;
			end else begin
				col_n = next_col;
				if (col_q == '0) begin
					row_acc_n  = row_sum[STEP_W-1:0];
					row_drop_n = row_sum[STEP_W];
				end
				col_acc_n      = drop_row ? col_base : col_sum[STEP_W-1:0];
				live           = !drop_row && !col_sum[STEP_W];
				job_d.pixel    = in_pixel;
				job_d.ends_row = at_end;
			end
		end else if (in_req == REQ_PIXEL) begin
			if (replays_q != '0) begin
				job_d.err = 1'b1;
			end else begin
				do_write = 1'b1;
				col_n    = next_col;
				if (at_end) begin
					replays_n = RW'(factor_eff - FACTOR_W'(1));
				end
				job_d.pixel    = in_pixel;
				job_d.count    = factor_eff;
				job_d.ends_row = at_end;
			end
		end else begin
			if (replays_q == '0) begin
				job_d.err = 1'b1;
			end else begin
				do_read = 1'b1;
				col_n   = next_col;
				if (at_end) begin
					replays_n = replays_q - RW'(1);
				end
				job_d.use_store = 1'b1;
				job_d.count     = factor_eff;
				job_d.ends_row  = at_end;
			end
		end
	end

	// store write on a new pixel, store read lands with the decided job
	assign mem_we    = accept && do_write;
	assign mem_re    = accept && do_read;
	assign mem_addr  = col_q;
	assign mem_wdata = in_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_acc_q   <= '0;
			col_acc_q   <= '0;
			row_drop_q  <= 1'b0;
			replays_q   <= '0;
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			col_q       <= col_n;
			row_acc_q   <= row_acc_n;
			col_acc_q   <= col_acc_n;
			row_drop_q  <= row_drop_n;
			replays_q   <= replays_n;
			s1_valid_s1 <= live;
		end else if (job_take) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_d;
		end
	end

	assign job_valid = s1_valid_s1;
	assign job       = job_s1;

endmodule

[rtl/core/psns_emit.sv]
// output repeater: sends one job's pixel count times
module psns_emit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	input  psns_pkg::job_t               job,
	input  logic [psns_pkg::PIX_W-1:0]   store_data,
	output logic                         job_take,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [psns_pkg::PIX_W-1:0]   m_tdata,
	output logic                         m_tlast,
	output logic [1:0]                   m_tuser
);
	import psns_pkg::*;

	logic                valid_s2;
	logic [PIX_W-1:0]    pixel_s2;
	logic [FACTOR_W-1:0] rem_s2;
	logic                ends_row_s2;
	logic                err_s2;
	logic                fire, last;

	assign fire     = valid_s2 && m_tready;
	assign last     = (rem_s2 == FACTOR_W'(1));
	assign job_take = !valid_s2 || (fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (job_take) begin
			valid_s2 <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (job_take && job_valid) begin
			pixel_s2    <= job.use_store ? store_data : job.pixel;
			rem_s2      <= job.count;
			ends_row_s2 <= job.ends_row;
			err_s2      <= job.err;
		end else if (fire) begin
			rem_s2 <= rem_s2 - FACTOR_W'(1);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = pixel_s2;
	assign m_tlast  = last;
	assign m_tuser  = {err_s2, ends_row_s2 && last};

endmodule

[rtl/core/pixel_stream_nearest_scaler.sv]
// top level of the nearest-neighbor pixel stream scaler
// path: a request is registered in the decision stage, then in the output register
// throughput: one request per cycle unless stalled by m_tready or a multi-copy run;
//   a grow request holds the repeater for grow_factor beats (one per ready cycle)
// line store: single write port and one registered read port, no clearing pass
// reset: arst_n clears config to defaults, scaling state and both stage valids at once
module pixel_stream_nearest_scaler #(
	parameter int unsigned MAX_WIDTH  = psns_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_FACTOR = psns_pkg::DEF_MAX_FACTOR
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_we,
	input  logic [psns_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psns_pkg::CFG_DATA_W-1:0] cfg_data,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [psns_pkg::PIX_W-1:0]      s_tdata,  // pixel_in
	input  logic                            s_tuser,  // req_type
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [psns_pkg::PIX_W-1:0]      m_tdata,  // pixel_out
	output logic                            m_tlast,  // last_of_run
	output logic [1:0]                      m_tuser   // order_error, row_done
);
	import psns_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);

	logic             job_valid, job_take;
	job_t             job;
	logic             mem_we, mem_re;
	logic [CW-1:0]    mem_addr;
	logic [PIX_W-1:0] mem_wdata, mem_rdata;

	// decision stage: owns the counters and accumulators, issues store accesses
	psns_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR),
		.CW         (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (s_tuser),
		.in_pixel  (s_tdata),
		.job_take  (job_take),
		.job_valid (job_valid),
		.job       (job),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata)
	);

	// one input row kept for replaying in grow mode
	psns_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

	// output register and copy counter
	psns_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.store_data (mem_rdata),
		.job_take   (job_take),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

[rtl/core/psns_checker.sv]
// port-level checks for the scaler and their binding to the top level
module psns_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [psns_pkg::PIX_W-1:0]   m_tdata,
	input logic                         m_tlast,
	input logic [1:0]                   m_tuser
);

	// an error result is a single zero beat that never ends a row
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == '0) && !m_tuser[0])
		else $error("order error beat malformed");

	// a row only ends on the last copy of a run
	a_row_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("row_done outside last beat");

	// copies of a run follow each other without a gap
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tdata))
		else $error("run broken before its last copy");

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind pixel_stream_nearest_scaler psns_checker u_psns_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
